// ===== design/hvc_pkg.sv =====
`default_nettype none
package hvc_pkg;

	localparam int CNT_W = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int NUM_CLASS = 4;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISC_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTERS = 3'd5;

	typedef logic [1:0] chart_class_t;
	localparam chart_class_t CLS_SINGLE = 2'd0;
	localparam chart_class_t CLS_COOP = 2'd1;
	localparam chart_class_t CLS_DOUBLE = 2'd2;
	localparam chart_class_t CLS_HALFDOUBLE = 2'd3;

	localparam logic [7:0] HUE_SINGLE_HI = 8'd22;
	localparam logic [7:0] HUE_WRAP_LO = 8'd168;
	localparam logic [7:0] HUE_WRAP_HI = 8'd179;
	localparam logic [7:0] HUE_COOP_LO = 8'd23;
	localparam logic [7:0] HUE_COOP_HI = 8'd34;
	localparam logic [7:0] HUE_DOUBLE_LO = 8'd35;
	localparam logic [7:0] HUE_DOUBLE_HI = 8'd85;
	localparam logic [7:0] HUE_HALF_LO = 8'd86;
	localparam logic [7:0] HUE_HALF_HI = 8'd130;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QLVL_W = 3;

	typedef struct packed {
		logic [8:0] width;
		logic [8:0] height;
		logic [8:0] radius;
		logic [7:0] sat_min;
		logic [7:0] bright_min;
	} front_cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [NUM_CLASS-1:0][CNT_W-1:0] votes;
	} tally_t;

endpackage
`default_nettype wire

// ===== design/hvc_if.sv =====
`default_nettype none
interface hvc_pixel_if;
	logic valid;
	logic ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic frame_end;
	modport source(output valid, blue, green, red, frame_end, input ready);
	modport sink(input valid, blue, green, red, frame_end, output ready);
endinterface

interface hvc_result_if;
	logic valid;
	logic ready;
	logic found;
	logic [1:0] chart_class;
	logic [16:0] best_count;
	logic [16:0] voter_total;
	logic [16:0] confidence;
	modport source(output valid, found, chart_class, best_count, voter_total, confidence,
		input ready);
	modport sink(input valid, found, chart_class, best_count, voter_total, confidence,
		output ready);
endinterface

interface hvc_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [16:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/hue_vote_color_classifier.sv =====
// Channel   Role   Fields
// pix       sink   blue, green, red, frame_end
// res       source found, chart_class, best_count, voter_total, confidence
// cfg       sink   index, data (always ready)
//
// Pixels are accepted one per cycle while the tally queue has room.
// Pixels are counted after registers s1 and s2; the total is queued with the last one.
// Only a found class runs the serial divider; a rejected result goes straight to done.
// Reset clears the position, the counters and the queue and loads the default registers.
// A stalled result holds the back end; the front keeps accepting until the queue fills.
`default_nettype none
module hue_vote_color_classifier #(
	parameter int MAX_DIM = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	hvc_pixel_if.sink pix,
	hvc_result_if.source res,
	hvc_cfg_if.sink cfg
);

	hvc_pkg::front_cfg_t fcfg_q;
	logic [hvc_pkg::CNT_W-1:0] min_voters_q;
	logic push, pop;
	hvc_pkg::tally_t tally, head;
	logic [hvc_pkg::QLVL_W-1:0] level;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcfg_q.width <= 9'd64;
			fcfg_q.height <= 9'd64;
			fcfg_q.radius <= 9'd32;
			fcfg_q.sat_min <= 8'd80;
			fcfg_q.bright_min <= 8'd60;
			min_voters_q <= 17'd20;
		end else if (cfg.valid) begin
			case (cfg.index)
				hvc_pkg::CFG_REGION_WIDTH: fcfg_q.width <= cfg.data[8:0];
				hvc_pkg::CFG_REGION_HEIGHT: fcfg_q.height <= cfg.data[8:0];
				hvc_pkg::CFG_DISC_RADIUS: fcfg_q.radius <= cfg.data[8:0];
				hvc_pkg::CFG_SATURATION_MIN: fcfg_q.sat_min <= cfg.data[7:0];
				hvc_pkg::CFG_BRIGHTNESS_MIN: fcfg_q.bright_min <= cfg.data[7:0];
				hvc_pkg::CFG_MIN_VOTERS: min_voters_q <= cfg.data;
				default: ;
			endcase
		end
	end

	hvc_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.cfg(fcfg_q),
		.q_level(level),
		.push(push),
		.tally(tally)
	);

	hvc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(tally),
		.pop(pop),
		.rd_data(head),
		.level(level)
	);

	hvc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_level(level),
		.min_voters(min_voters_q),
		.pop(pop),
		.res(res)
	);

endmodule
`default_nettype wire

// ===== design/hvc_front.sv =====
`default_nettype none
module hvc_front #(
	parameter int MAX_DIM = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	hvc_pixel_if.sink pix,
	input hvc_pkg::front_cfg_t cfg,
	input wire logic [hvc_pkg::QLVL_W-1:0] q_level,
	output logic push,
	output hvc_pkg::tally_t tally
);

	localparam int PW = $clog2(MAX_DIM);
	localparam int XW = ((PW + 1 > 9) ? PW + 1 : 9) + 2;
	localparam int DW = 2 * XW + 1;

	logic [19:0] srecip_tab [256];
	logic [16:0] hrecip_tab [256];

	for (genvar i = 0; i < 256; i++) begin : g_tab
		localparam int SR = (i == 0) ? 0 : (2 * 1044480 + i) / ((i == 0) ? 1 : 2 * i);
		localparam int HR = (i == 0) ? 0 : (245760 + i) / ((i == 0) ? 1 : 2 * i);
		assign srecip_tab[i] = 20'(SR);
		assign hrecip_tab[i] = 17'(HR);
	end

	logic [PW-1:0] col_q, row_q;
	logic [19:0] rr_q;
	logic [17:0] r_sq;
	logic [XW-1:0] w_c, h_c, col_nx, row_nx;
	logic accept;
	logic [7:0] mx, mn, diff;
	logic signed [11:0] bs, gs, rs, ds, hh;
	logic signed [XW-1:0] dx, dy;

	logic v_s1, last_s1;
	logic [7:0] diff_s1, mx_s1;
	logic [19:0] srec_s1;
	logic [16:0] hrec_s1;
	logic signed [11:0] hh_s1;
	logic signed [XW-1:0] dx_s1, dy_s1;

	logic [27:0] s_sum;
	logic [7:0] sat;
	logic signed [29:0] hp, hsh;
	logic [7:0] hue;
	logic signed [2*XW-1:0] dxx, dyy;
	logic [DW-1:0] d2;
	logic vote;

	logic v_s2, last_s2, vote_s2;
	logic [7:0] hue_s2;

	logic [hvc_pkg::CNT_W-1:0] total_q;
	logic [hvc_pkg::NUM_CLASS-1:0][hvc_pkg::CNT_W-1:0] votes_q, votes_n;
	logic [hvc_pkg::CNT_W-1:0] total_n;
	logic has_cls;
	hvc_pkg::chart_class_t cls;
	logic [1:0] pending;

	assign pending = 2'(v_s1 && last_s1) + 2'(v_s2 && last_s2);
	assign pix.ready = ({1'b0, q_level} + {2'b00, pending}) < (hvc_pkg::QLVL_W + 1)'(hvc_pkg::QUEUE_DEPTH);
	assign accept = pix.valid && pix.ready;

	always_comb begin
		if (cfg.width == '0) w_c = XW'(1);
		else if (XW'(cfg.width) > XW'(MAX_DIM)) w_c = XW'(MAX_DIM);
		else w_c = XW'(cfg.width);
		if (cfg.height == '0) h_c = XW'(1);
		else if (XW'(cfg.height) > XW'(MAX_DIM)) h_c = XW'(MAX_DIM);
		else h_c = XW'(cfg.height);
		col_nx = XW'(col_q) + XW'(1);
		row_nx = XW'(row_q) + XW'(1);
		dx = $signed(XW'({col_q, 1'b1}) - w_c);
		dy = $signed(XW'({row_q, 1'b1}) - h_c);
	end

	assign r_sq = {9'd0, cfg.radius} * {9'd0, cfg.radius};

	always_comb begin
		mx = pix.blue;
		mn = pix.blue;
		if (pix.green > mx) mx = pix.green;
		if (pix.red > mx) mx = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.red < mn) mn = pix.red;
		diff = mx - mn;
		bs = $signed({4'b0, pix.blue});
		gs = $signed({4'b0, pix.green});
		rs = $signed({4'b0, pix.red});
		ds = $signed({4'b0, diff});
		if (mx == pix.red) hh = gs - bs;
		else if (mx == pix.green) hh = bs - rs + (ds <<< 1);
		else hh = rs - gs + (ds <<< 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rr_q <= '0;
		end else begin
			rr_q <= {r_sq, 2'b00};
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				if (pix.frame_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_nx >= w_c) begin
					col_q <= '0;
					row_q <= (row_nx >= h_c) ? '0 : row_nx[PW-1:0];
				end else begin
					col_q <= col_nx[PW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= pix.frame_end;
		diff_s1 <= diff;
		mx_s1 <= mx;
		srec_s1 <= srecip_tab[mx];
		hrec_s1 <= hrecip_tab[diff];
		hh_s1 <= hh;
		dx_s1 <= dx;
		dy_s1 <= dy;
	end

	always_comb begin
		s_sum = 28'(diff_s1 * srec_s1) + 28'd2048;
		sat = s_sum[19:12];
		hp = hh_s1 * $signed({1'b0, hrec_s1});
		hsh = (hp + 30'sd2048) >>> 12;
		hue = hsh[29] ? (hsh[7:0] + 8'd180) : hsh[7:0];
		dxx = dx_s1 * dx_s1;
		dyy = dy_s1 * dy_s1;
		d2 = {1'b0, dxx} + {1'b0, dyy};
		vote = (sat > cfg.sat_min) && (mx_s1 > cfg.bright_min) && (d2 <= DW'(rr_q));
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		vote_s2 <= vote;
		hue_s2 <= hue;
	end

	always_comb begin
		has_cls = 1'b1;
		cls = hvc_pkg::CLS_SINGLE;
		if (hue_s2 inside {[8'd0 : hvc_pkg::HUE_SINGLE_HI],
				[hvc_pkg::HUE_WRAP_LO : hvc_pkg::HUE_WRAP_HI]}) begin
			cls = hvc_pkg::CLS_SINGLE;
		end else if (hue_s2 inside {[hvc_pkg::HUE_COOP_LO : hvc_pkg::HUE_COOP_HI]}) begin
			cls = hvc_pkg::CLS_COOP;
		end else if (hue_s2 inside {[hvc_pkg::HUE_DOUBLE_LO : hvc_pkg::HUE_DOUBLE_HI]}) begin
			cls = hvc_pkg::CLS_DOUBLE;
		end else if (hue_s2 inside {[hvc_pkg::HUE_HALF_LO : hvc_pkg::HUE_HALF_HI]}) begin
			cls = hvc_pkg::CLS_HALFDOUBLE;
		end else begin
			has_cls = 1'b0;
		end
		total_n = total_q;
		votes_n = votes_q;
		if (v_s2 && vote_s2) begin
			if (total_q != hvc_pkg::CNT_MAX) total_n = total_q + 1'b1;
			if (has_cls && votes_q[cls] != hvc_pkg::CNT_MAX) votes_n[cls] = votes_q[cls] + 1'b1;
		end
	end

	assign push = v_s2 && last_s2;
	assign tally.total = total_n;
	assign tally.votes = votes_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			votes_q <= '0;
		end else if (push) begin
			total_q <= '0;
			votes_q <= '0;
		end else begin
			total_q <= total_n;
			votes_q <= votes_n;
		end
	end

endmodule
`default_nettype wire

// ===== design/hvc_queue.sv =====
`default_nettype none
module hvc_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input hvc_pkg::tally_t wr_data,
	input wire logic pop,
	output hvc_pkg::tally_t rd_data,
	output logic [hvc_pkg::QLVL_W-1:0] level
);

	hvc_pkg::tally_t mem_q [hvc_pkg::QUEUE_DEPTH];
	logic [hvc_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [hvc_pkg::QLVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			level_q <= level_q + hvc_pkg::QLVL_W'(push) - hvc_pkg::QLVL_W'(pop);
		end
	end

	assign rd_data = mem_q[rd_q];
	assign level = level_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> level_q < hvc_pkg::QLVL_W'(hvc_pkg::QUEUE_DEPTH))
		else $error("Tally pushed into a full queue.");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> level_q != '0)
		else $error("Tally popped from an empty queue.");
`endif

endmodule
`default_nettype wire

// ===== design/hvc_back.sv =====
`default_nettype none
module hvc_back (
	input wire logic clk,
	input wire logic arst_n,
	input hvc_pkg::tally_t head,
	input wire logic [hvc_pkg::QLVL_W-1:0] q_level,
	input wire logic [hvc_pkg::CNT_W-1:0] min_voters,
	output logic pop,
	hvc_result_if.source res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic found_q;
	hvc_pkg::chart_class_t cls_q;
	logic [16:0] best_q, total_q, quot_q;
	logic [17:0] rem_q, div_q;
	logic [4:0] cnt_q;

	logic [16:0] best;
	hvc_pkg::chart_class_t cls;
	logic ok;
	logic [34:0] num;
	logic [18:0] rem_sh;
	logic qbit;

	always_comb begin
		best = '0;
		cls = hvc_pkg::CLS_SINGLE;
		for (int k = 0; k < hvc_pkg::NUM_CLASS; k++) begin
			if (head.votes[k] > best) begin
				best = head.votes[k];
				cls = hvc_pkg::chart_class_t'(k);
			end
		end
		ok = (head.total >= min_voters) && (best != '0) && (head.total != '0);
		num = {1'b0, best, 17'd0} + {18'd0, head.total};
		rem_sh = {rem_q, quot_q[16]};
		qbit = rem_sh >= {1'b0, div_q};
	end

	assign pop = (state_q == ST_IDLE) && (q_level != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ok ? ST_DIV : ST_DONE;
						cnt_q <= 5'd17;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 5'd1) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			found_q <= ok;
			cls_q <= ok ? cls : hvc_pkg::CLS_SINGLE;
			best_q <= ok ? best : '0;
			total_q <= head.total;
			rem_q <= num[34:17];
			quot_q <= ok ? num[16:0] : '0;
			div_q <= {head.total, 1'b0};
		end else if (state_q == ST_DIV) begin
			rem_q <= qbit ? 18'(rem_sh - {1'b0, div_q}) : rem_sh[17:0];
			quot_q <= {quot_q[15:0], qbit};
		end
	end

	assign res.valid = (state_q == ST_DONE);
	assign res.found = found_q;
	assign res.chart_class = cls_q;
	assign res.best_count = best_q;
	assign res.voter_total = total_q;
	assign res.confidence = quot_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.found |-> res.best_count != '0 && res.best_count <= res.voter_total)
		else $error("Winning count is zero or above the voter total.");
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.found |-> res.confidence == '0 && res.best_count == '0)
		else $error("Rejected region carries a nonzero count or confidence.");
`endif

endmodule
`default_nettype wire
